FILE: hw/rtl/psrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psrp_pkg;

  // defaults for the top-level parameters
  localparam int IMAGES_DEF       = 2;
  localparam int MAX_CHANNELS_DEF = 512;
  localparam int MAX_HEIGHT_DEF   = 32;
  localparam int MAX_WIDTH_DEF    = 32;
  localparam int MAX_GROUP_DEF    = 8;

  // 0.1 in q0.16, rounded to nearest
  localparam int MIN_EXTENT = 6554;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ODIM  = 3'd4;

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_POOL  = 1'b1;

  // bin bound numerators and the shared divider
  localparam int NUM_W  = 34;
  localparam int DIV_NW = 28;
  localparam int DIV_DW = 13;
  localparam int SUM_W  = 29;

  typedef struct packed {
    logic [15:0] scale;
    logic [3:0]  group;
    logic [5:0]  fh;
    logic [5:0]  fw;
    logic [3:0]  odim;
  } cfg_t;

  // request payload, first field in the top bits
  typedef struct packed {
    logic [3:0]         class_index;
    logic [11:0]        roi_y2;
    logic [11:0]        roi_x2;
    logic [11:0]        roi_y1;
    logic [11:0]        roi_x1;
    logic signed [15:0] feature_value;
    logic [4:0]         col;
    logic [4:0]         row;
    logic [8:0]         channel;
    logic               image_index;
  } req_t;

  typedef struct packed {
    logic       wr;
    logic       ld_roi;
    logic       geo1;
    logic       geo2;
    logic       geo3;
    logic       bin_ld;
    logic       div_go;
    logic       div_avg;
    logic       bnd_we;
    logic [1:0] bsel;
    logic       area_ld;
    logic       rd;
    logic       acc;
    logic       ld_out;
    logic       step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic valid;
    logic empty;
    logic last_pix;
    logic last_bin;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/psrp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module psrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/psrp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module psrp_div import psrp_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire  [DIV_NW-1:0] dividend,
  input  wire  [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_DW:0]   trial;
  logic              qbit;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial    = {rem_r, quo_r[DIV_NW-1]};
    qbit     = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, dvs_r});
        qbit    = 1'b1;
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
      end
      quo_nxt = {quo_r[DIV_NW-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: hw/rtl/psrp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module psrp_ctrl import psrp_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_tvalid,
  input  wire   in_opcode,
  output logic  in_tready,
  output logic  out_tvalid,
  input  wire   out_tready,
  input  sts_t  sts,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GEO1 = 4'd1;
  localparam logic [3:0] S_GEO2 = 4'd2;
  localparam logic [3:0] S_GEO3 = 4'd3;
  localparam logic [3:0] S_BIN  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_BND  = 4'd6;
  localparam logic [3:0] S_BNDW = 4'd7;
  localparam logic [3:0] S_AREA = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_AVG  = 4'd11;
  localparam logic [3:0] S_AVGW = 4'd12;
  localparam logic [3:0] S_LOAD = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [1:0] bidx_r, bidx_nxt;

  always_comb begin
    state_nxt  = state_r;
    bidx_nxt   = bidx_r;
    cmd        = '0;
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_opcode == OP_POOL) begin
            cmd.ld_roi = 1'b1;
            state_nxt  = S_GEO1;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_GEO1: begin
        cmd.geo1  = 1'b1;
        state_nxt = S_GEO2;
      end
      S_GEO2: begin
        cmd.geo2  = 1'b1;
        state_nxt = S_GEO3;
      end
      S_GEO3: begin
        cmd.geo3  = 1'b1;
        state_nxt = S_BIN;
      end
      S_BIN: begin
        cmd.bin_ld = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        bidx_nxt  = 2'd0;
        state_nxt = sts.valid ? S_BND : S_LOAD;
      end
      S_BND: begin
        cmd.div_go = 1'b1;
        cmd.bsel   = bidx_r;
        state_nxt  = S_BNDW;
      end
      S_BNDW: begin
        cmd.bsel = bidx_r;
        if (sts.div_done) begin
          cmd.bnd_we = 1'b1;
          bidx_nxt   = bidx_r + 2'd1;
          state_nxt  = (bidx_r == 2'd3) ? S_AREA : S_BND;
        end
      end
      S_AREA: begin
        cmd.area_ld = 1'b1;
        state_nxt   = sts.empty ? S_LOAD : S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_pix ? S_AVG : S_RD;
      end
      S_AVG: begin
        cmd.div_go  = 1'b1;
        cmd.div_avg = 1'b1;
        state_nxt   = S_AVGW;
      end
      S_AVGW: begin
        if (sts.div_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.ld_out = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          if (sts.last_bin) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_BIN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bidx_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      bidx_r  <= bidx_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/psrp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module psrp_dp import psrp_pkg::*; #(
  parameter int IMAGES       = IMAGES_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int MAX_GROUP    = MAX_GROUP_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  cfg_t                   cfg,
  input  req_t                   req,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic [OUT_DATA_W-1:0]  out_data,
  output logic                   out_empty,
  output logic                   out_last
);

  localparam int IMG_W = (IMAGES > 1) ? $clog2(IMAGES) : 1;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW    = IMG_W + CH_W + RW_W + CL_W;
  localparam int DEPTH = 1 << AW;

  // roi request fields
  logic        img_r;
  logic [3:0]  cls_r;
  logic [11:0] x1_r, y1_r, x2_r, y2_r;
  // geometry
  logic [27:0] sx_r, sy_r;
  logic [28:0] ex_r, ey_r;
  logic [28:0] extw_r, exth_r;
  logic [31:0] bx_r, by_r;
  logic [NUM_W-1:0] bx1_r, by1_r;
  logic [NUM_W-1:0] nx0_r, nx1_r, ny0_r, ny1_r;
  // bin state
  logic [2:0]  r_r, c_r;
  logic [11:0] ch_r;
  logic        valid_r;
  logic [6:0]  hs_r, he_r, ws_r, we_r, yy_r, xx_r;
  logic [DIV_DW-1:0] area_r;
  logic signed [SUM_W-1:0] sum_r;
  // result register
  logic [15:0] pooled_r;
  logic [2:0]  orow_r, ocol_r;
  logic [8:0]  och_r;
  logic        oempty_r, olast_r;

  logic [3:0]  g;
  logic [19:0] gm1;
  logic [6:0]  h_lim, w_lim;
  logic [28:0] dx, dy;
  logic [11:0] ch_calc;
  logic        bins_empty;
  logic [SUM_W-1:0] mag;
  logic              neg;
  logic [DIV_NW-1:0] div_num, quo, qneg;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [6:0]  bnd_lim, bnd_clip;
  logic [15:0] rdata;
  logic        wr_ok;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] w_img, w_ch, w_row, w_col, r_img, r_ch, r_row, r_col;

  // group size saturated into 1..MAX_GROUP, sizes saturated to the store
  always_comb begin
    if (cfg.group == 4'd0) begin
      g = 4'd1;
    end else if (32'(cfg.group) > MAX_GROUP) begin
      g = 4'(MAX_GROUP);
    end else begin
      g = cfg.group;
    end
    gm1   = {g, 16'h0000} - 20'd1;
    h_lim = (32'(cfg.fh) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : {1'b0, cfg.fh};
    w_lim = (32'(cfg.fw) > MAX_WIDTH) ? 7'(MAX_WIDTH) : {1'b0, cfg.fw};
  end

  assign dx = ex_r - {1'b0, sx_r};
  assign dy = ey_r - {1'b0, sy_r};
  assign ch_calc = 12'((8'(cls_r) * 8'(g) + 8'(r_r)) * 12'(g)) + 12'(c_r);
  assign bins_empty = !valid_r || !((he_r > hs_r) && (we_r > ws_r));
  assign neg = sum_r[SUM_W-1];
  assign mag = neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign qneg = DIV_NW'(-quo);

  // divider operand selection
  always_comb begin
    if (cmd.div_avg) begin
      div_num = mag[DIV_NW-1:0];
      div_den = area_r;
    end else begin
      unique case (cmd.bsel)
        2'd0:    div_num = DIV_NW'(ny0_r[NUM_W-1:16]);
        2'd1:    div_num = DIV_NW'(ny1_r[NUM_W-1:16]);
        2'd2:    div_num = DIV_NW'(nx0_r[NUM_W-1:16]);
        default: div_num = DIV_NW'(nx1_r[NUM_W-1:16]);
      endcase
      div_den = DIV_DW'(g);
    end
    bnd_lim  = cmd.bsel[1] ? w_lim : h_lim;
    bnd_clip = (quo > DIV_NW'(bnd_lim)) ? bnd_lim : quo[6:0];
  end

  psrp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quo)
  );

  // store address: image, channel, row, column fields
  always_comb begin
    w_img = 32'(req.image_index);
    w_ch  = 32'(req.channel);
    w_row = 32'(req.row);
    w_col = 32'(req.col);
    r_img = 32'(img_r);
    r_ch  = 32'(ch_r);
    r_row = 32'(yy_r);
    r_col = 32'(xx_r);
    wr_ok = (w_img < IMAGES) && (w_ch < MAX_CHANNELS) && (w_row < MAX_HEIGHT)
            && (w_col < MAX_WIDTH);
    waddr = {w_img[IMG_W-1:0], w_ch[CH_W-1:0], w_row[RW_W-1:0], w_col[CL_W-1:0]};
    raddr = {r_img[IMG_W-1:0], r_ch[CH_W-1:0], r_row[RW_W-1:0], r_col[CL_W-1:0]};
  end

  psrp_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr && wr_ok),
    .waddr (waddr),
    .wdata (req.feature_value),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_roi) begin
      img_r <= req.image_index;
      cls_r <= req.class_index;
      x1_r  <= req.roi_x1;
      y1_r  <= req.roi_y1;
      x2_r  <= req.roi_x2;
      y2_r  <= req.roi_y2;
    end
    if (cmd.geo1) begin
      sx_r <= 28'(x1_r) * 28'(cfg.scale);
      sy_r <= 28'(y1_r) * 28'(cfg.scale);
      ex_r <= (29'(x2_r) + 29'd1) * 29'(cfg.scale);
      ey_r <= (29'(y2_r) + 29'd1) * 29'(cfg.scale);
    end
    if (cmd.geo2) begin
      extw_r <= (ex_r > {1'b0, sx_r} && dx >= 29'(MIN_EXTENT)) ? dx : 29'(MIN_EXTENT);
      exth_r <= (ey_r > {1'b0, sy_r} && dy >= 29'(MIN_EXTENT)) ? dy : 29'(MIN_EXTENT);
      bx_r   <= 32'(sx_r) * 32'(g);
      by_r   <= 32'(sy_r) * 32'(g);
    end
    if (cmd.geo3) begin
      bx1_r <= NUM_W'(bx_r) + NUM_W'(extw_r) + NUM_W'(gm1);
      by1_r <= NUM_W'(by_r) + NUM_W'(exth_r) + NUM_W'(gm1);
      nx0_r <= NUM_W'(bx_r);
      nx1_r <= NUM_W'(bx_r) + NUM_W'(extw_r) + NUM_W'(gm1);
      ny0_r <= NUM_W'(by_r);
      ny1_r <= NUM_W'(by_r) + NUM_W'(exth_r) + NUM_W'(gm1);
      r_r   <= 3'd0;
      c_r   <= 3'd0;
    end
    if (cmd.step) begin
      if (4'(c_r) == g - 4'd1) begin
        c_r   <= 3'd0;
        r_r   <= r_r + 3'd1;
        nx0_r <= NUM_W'(bx_r);
        nx1_r <= bx1_r;
        ny0_r <= ny0_r + NUM_W'(exth_r);
        ny1_r <= ny1_r + NUM_W'(exth_r);
      end else begin
        c_r   <= c_r + 3'd1;
        nx0_r <= nx0_r + NUM_W'(extw_r);
        nx1_r <= nx1_r + NUM_W'(extw_r);
      end
    end
    if (cmd.bin_ld) begin
      ch_r    <= ch_calc;
      valid_r <= (cls_r < cfg.odim) && (32'(ch_calc) < MAX_CHANNELS)
                 && (32'(img_r) < IMAGES);
    end
    if (cmd.bnd_we) begin
      unique case (cmd.bsel)
        2'd0:    hs_r <= bnd_clip;
        2'd1:    he_r <= bnd_clip;
        2'd2:    ws_r <= bnd_clip;
        default: we_r <= bnd_clip;
      endcase
    end
    if (cmd.area_ld) begin
      area_r <= DIV_DW'(14'(he_r - hs_r) * 14'(we_r - ws_r));
      yy_r   <= hs_r;
      xx_r   <= ws_r;
      sum_r  <= '0;
    end
    if (cmd.acc) begin
      sum_r <= sum_r + SUM_W'($signed(rdata));
      if (xx_r == we_r - 7'd1) begin
        xx_r <= ws_r;
        yy_r <= yy_r + 7'd1;
      end else begin
        xx_r <= xx_r + 7'd1;
      end
    end
    if (cmd.ld_out) begin
      pooled_r <= bins_empty ? 16'd0 : (neg ? qneg[15:0] : quo[15:0]);
      orow_r   <= r_r;
      ocol_r   <= c_r;
      och_r    <= valid_r ? ch_r[8:0] : 9'd0;
      oempty_r <= bins_empty;
      olast_r  <= sts.last_bin;
    end
  end

  always_comb begin
    sts.div_done = div_done;
    sts.valid    = valid_r;
    sts.empty    = bins_empty;
    sts.last_pix = (yy_r == he_r - 7'd1) && (xx_r == we_r - 7'd1);
    sts.last_bin = (4'(r_r) == g - 4'd1) && (4'(c_r) == g - 4'd1);
  end

  assign out_data  = {1'b0, och_r, ocol_r, orow_r, pooled_r};
  assign out_empty = oempty_r;
  assign out_last  = olast_r;

endmodule
`default_nettype wire

FILE: hw/rtl/psroi_pool_forward_unit.sv
// flow: a feature write is stored straight from the idle state; an roi is latched and passes
//   the geometry steps, then each bin loads its channel, runs the four bound divisions, reads
//   and sums its pixels, divides by the area for the average and hands over the result
// pace: one request at a time; the shared divider and the single store read port set the pace;
//   an invalid bin skips the divisions and the pixels, an empty one the pixels and the average
// reset: synchronous active-low; control and config go to defaults, the feature store keeps
//   its contents and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module psroi_pool_forward_unit import psrp_pkg::*; #(
  parameter int IMAGES       = IMAGES_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int MAX_GROUP    = MAX_GROUP_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // config write port
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_addr,
  input  wire  [CFG_DATA_W-1:0]  cfg_wdata,
  // request channel
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // image_index, channel, row, col, feature_value, roi_x1, roi_y1, roi_x2, roi_y2,
  // class_index
  input  wire  [IN_DATA_W-1:0]   in_tdata,
  input  wire                    in_tuser,  // opcode
  // result channel
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // pooled_value, bin_row, bin_col, source_channel, one pad bit
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tuser,  // bin_empty
  output logic                   out_tlast   // last_bin
);

  cfg_t cfg_r, cfg_nxt;
  req_t req;
  cmd_t cmd;
  sts_t sts;

  assign req = in_tdata;

  // config registers, indexes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCALE: cfg_nxt.scale = cfg_wdata;
        REG_GROUP: cfg_nxt.group = cfg_wdata[3:0];
        REG_FH:    cfg_nxt.fh    = cfg_wdata[5:0];
        REG_FW:    cfg_nxt.fw    = cfg_wdata[5:0];
        REG_ODIM:  cfg_nxt.odim  = cfg_wdata[3:0];
        default:   cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale <= 16'd4096;
      cfg_r.group <= 4'd7;
      cfg_r.fh    <= 6'd32;
      cfg_r.fw    <= 6'd32;
      cfg_r.odim  <= 4'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: one request at a time, one bin at a time
  psrp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // bin geometry, feature store, accumulator, divider and result register
  psrp_dp #(
    .IMAGES       (IMAGES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_GROUP    (MAX_GROUP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata),
    .out_empty (out_tuser),
    .out_last  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import psrp_pkg::*;

  localparam int  FEAT_CH     = 512;       // channels held in the feature store
  localparam int  FEAT_DIM    = 32;        // rows and columns held per channel
  localparam int  GROUP_CAP   = 8;
  localparam int  FILL_BUDGET = 250;       // fresh pixels one roi may pull in before shrinking
  localparam int  RAND_PER_PH = 55;
  localparam int  TIMEOUT     = 40000000;
  localparam int  HOLD_CYCLES = 3000;

  // one request as the sender presents it
  typedef struct {
    logic op;
    req_t d;
  } request_t;

  // one pooled bin as the block returns it
  typedef struct packed {
    logic signed [15:0] pooled;
    logic [2:0]         brow;
    logic [2:0]         bcol;
    logic [8:0]         src_ch;
    logic               empty;
    logic               last;
  } bin_res_t;

  typedef struct {
    int scale;
    int grp;
    int fh;
    int fw;
    int odim;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  psroi_pool_forward_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // image_index, channel, row, col, feature_value, x1, y1, x2, y2, class
    .in_tuser  (in_tuser),   // opcode
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // pooled_value, bin_row, bin_col, source_channel, pad
    .out_tuser (out_tuser),  // bin_empty
    .out_tlast (out_tlast)   // last_bin
  );

  always #5 clk = ~clk;

  // requests waiting for the driver and bins waiting for the block
  request_t           req_q[$];
  bin_res_t           bin_q[$];
  logic signed [15:0] feat_mem[int];   // only pixels that have been written

  // shadow of the configuration registers
  int cur_scale = 4096;
  int cur_grp   = 7;
  int cur_fh    = 32;
  int cur_fw    = 32;
  int cur_odim  = 8;

  int send_idle = 0;
  int recv_idle = 0;
  int errors    = 0;
  int cycles    = 0;
  bit hold_go   = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cnt  = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT) begin
      $display("** psroi_pool_forward_unit: FAILED **");
      $finish;
    end
  end

  // long receiver hold-off, so the block fills and backs up its input
  always @(posedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // driver: offers the next request, holds it until accepted
  always @(posedge clk) begin : drive_b
    request_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        it = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.d;
        in_tuser  <= it.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: each accepted bin against the oldest prediction
  always @(posedge clk) begin : mon_b
    bin_res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.pooled = out_tdata[15:0];
        got.brow   = out_tdata[18:16];
        got.bcol   = out_tdata[21:19];
        got.src_ch = out_tdata[30:22];
        got.empty  = out_tuser;
        got.last   = out_tlast;
        if (bin_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected bin: value %0d row %0d col %0d ch %0d empty %0b last %0b",
                     got.pooled, got.brow, got.bcol, got.src_ch, got.empty, got.last);
        end else begin
          want = bin_q.pop_front();
          if (got != want) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("bin mismatch: exp v%0d r%0d c%0d ch%0d e%0b l%0b, got v%0d r%0d c%0d ch%0d e%0b l%0b",
                       want.pooled, want.brow, want.bcol, want.src_ch, want.empty, want.last,
                       got.pooled, got.brow, got.bcol, got.src_ch, got.empty, got.last);
          end
        end
      end
      out_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic int pix_key(int img, int ch, int r, int c);
    return ((img * FEAT_CH + ch) * FEAT_DIM + r) * FEAT_DIM + c;
  endfunction

  // scaled roi extent along one axis, q.16, never below the 0.1 floor
  function automatic longint unsigned roi_extent(longint unsigned lo, longint unsigned hi);
    longint unsigned a, b;
    a = lo * cur_scale;
    b = (hi + 1) * cur_scale;
    if (b <= a || b - a < MIN_EXTENT) return MIN_EXTENT;
    return b - a;
  endfunction

  // floor of the lower and ceil of the upper bin edge, clipped to the map
  task automatic bin_edges(input longint unsigned lo, input longint unsigned ext, input int k,
                           input int g, input int lim, output int bs, output int be);
    longint unsigned d, base, n0, n1, f, c;
    d    = longint'(g) * 65536;
    base = lo * cur_scale * g;
    n0   = base + k * ext;
    n1   = base + (k + 1) * ext;
    f    = n0 / d;
    c    = (n1 + d - 1) / d;
    if (f > lim) f = lim;
    if (c > lim) c = lim;
    bs = int'(f);
    be = int'(c);
  endtask

  function automatic req_t noise_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return req_t'(raw[IN_DATA_W-1:0]);
  endfunction

  task automatic push_write(input req_t q);
    request_t it;
    it.op = OP_WRITE;
    it.d  = q;
    req_q.push_back(it);
    feat_mem[pix_key(q.image_index, q.channel, q.row, q.col)] = q.feature_value;
  endtask

  // walks every bin of an roi: what 0 counts unwritten pixels, 1 writes them first,
  // 2 predicts the averaged bins
  task automatic walk_roi(input req_t q, input int what, output int missing);
    int g, h, w, cls, ch, hs, he, ws, we, key;
    longint unsigned ew, eh;
    longint sum, area;
    bit valid;
    bin_res_t e;
    req_t wq;
    g   = (cur_grp == 0) ? 1 : ((cur_grp > GROUP_CAP) ? GROUP_CAP : cur_grp);
    h   = (cur_fh > FEAT_DIM) ? FEAT_DIM : cur_fh;
    w   = (cur_fw > FEAT_DIM) ? FEAT_DIM : cur_fw;
    cls = q.class_index;
    ew  = roi_extent(q.roi_x1, q.roi_x2);
    eh  = roi_extent(q.roi_y1, q.roi_y2);
    missing = 0;
    for (int r = 0; r < g; r++) begin
      for (int c = 0; c < g; c++) begin
        ch    = (cls * g + r) * g + c;
        valid = (cls < cur_odim) && (ch < FEAT_CH);
        e.pooled = '0;
        e.empty  = 1'b1;
        sum      = 0;
        if (valid) begin
          bin_edges(q.roi_y1, eh, r, g, h, hs, he);
          bin_edges(q.roi_x1, ew, c, g, w, ws, we);
          if (he > hs && we > ws) begin
            for (int yy = hs; yy < he; yy++) begin
              for (int xx = ws; xx < we; xx++) begin
                key = pix_key(q.image_index, ch, yy, xx);
                if (!feat_mem.exists(key)) begin
                  missing++;
                  if (what == 1) begin
                    wq = noise_req();
                    wq.image_index = q.image_index;
                    wq.channel = ch;
                    wq.row = yy;
                    wq.col = xx;
                    push_write(wq);
                  end
                end else if (what == 2) begin
                  sum += feat_mem[key];
                end
              end
            end
            area     = longint'(he - hs) * (we - ws);
            e.pooled = 16'(sum / area);   // truncates toward zero
            e.empty  = 1'b0;
          end
        end
        e.brow   = r;
        e.bcol   = c;
        e.src_ch = valid ? ch : 0;
        e.last   = (r == g - 1) && (c == g - 1);
        if (what == 2) bin_q.push_back(e);
      end
    end
  endtask

  // queues an roi, preceded by writes of any pixel it reads that was never written
  task automatic push_pool(input req_t q);
    int m;
    request_t it;
    walk_roi(q, 0, m);
    if (m > FILL_BUDGET) begin
      q.roi_x2 = q.roi_x1;
      q.roi_y2 = q.roi_y1;
    end
    walk_roi(q, 1, m);
    it.op = OP_POOL;
    it.d  = q;
    req_q.push_back(it);
    walk_roi(q, 2, m);
  endtask

  // roi edges mostly sized to the feature map, sometimes anywhere in the field range
  task automatic roi_axis(input int lim, output logic [11:0] a, output logic [11:0] b);
    int p, top, span;
    p = 65536 / cur_scale;
    if (p > 4095) p = 4095;
    if ($urandom_range(3) == 0) begin
      a = $urandom;
      b = $urandom;
    end else begin
      top = (lim + 1) * p;
      if (top > 4095) top = 4095;
      a = $urandom_range(top);
      span = ($urandom_range(3) == 0) ? lim * p : 2 * p;
      if (span > 4095 - a) span = 4095 - a;
      b = a + $urandom_range(span);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SCALE: cur_scale = val & 16'hffff;
      REG_GROUP: cur_grp   = val & 4'hf;
      REG_FH:    cur_fh    = val & 6'h3f;
      REG_FW:    cur_fw    = val & 6'h3f;
      REG_ODIM:  cur_odim  = val & 4'hf;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_tvalid || bin_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  setting_t settings[8] = '{
    '{65535, 1,  1,  1,  1},   // largest scale, single bin
    '{16384, 4,  8,  8, 10},
    '{1,     8,  4,  4,  3},   // tiny scale, extent held at the floor
    '{32768, 8,  6,  5,  8},   // classes within the count fill the channel store exactly
    '{4096,  2, 32, 32,  5},
    '{8192,  0,  0, 63, 15},   // group zero, zero height, saturated width
    '{20000, 15, 63, 3,  0},   // saturated group, no valid class
    '{2048,  3, 16, 12, 10}
  };

  initial begin : stim_b
    req_t q;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset settings
    send_idle = 0;
    recv_idle = 0;
    q = noise_req();
    q.image_index = 1; q.channel = 511; q.row = 31; q.col = 31; q.feature_value = 16'sh8000;
    push_write(q);
    q = noise_req();
    q.image_index = 0; q.channel = 0; q.row = 0; q.col = 0; q.feature_value = 16'sh7fff;
    push_write(q);
    q = noise_req();
    q.image_index = 0; q.channel = 0; q.row = 1; q.col = 0; q.feature_value = 16'sh8000;
    push_write(q);
    // small roi in the top-left corner
    q = noise_req();
    q.image_index = 0; q.class_index = 0;
    q.roi_x1 = 0; q.roi_y1 = 0; q.roi_x2 = 15; q.roi_y2 = 31;
    push_pool(q);
    // class at and beyond the class count
    q.class_index = 8;
    push_pool(q);
    q.class_index = 15;
    push_pool(q);
    // reversed corners fall back to the minimum extent
    q = noise_req();
    q.image_index = 1; q.class_index = 7;
    q.roi_x1 = 100; q.roi_x2 = 20; q.roi_y1 = 60; q.roi_y2 = 0;
    push_pool(q);
    // roi beyond the map gives empty bins
    q = noise_req();
    q.image_index = 1; q.class_index = 3;
    q.roi_x1 = 4095; q.roi_y1 = 4095; q.roi_x2 = 4095; q.roi_y2 = 4095;
    push_pool(q);
    // whole field range
    q = noise_req();
    q.image_index = 1; q.class_index = 1;
    q.roi_x1 = 0; q.roi_y1 = 0; q.roi_x2 = 4095; q.roi_y2 = 4095;
    push_pool(q);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_SCALE, settings[ph].scale);
      cfg_write(REG_GROUP, settings[ph].grp);
      cfg_write(REG_FH, settings[ph].fh);
      cfg_write(REG_FW, settings[ph].fw);
      cfg_write(REG_ODIM, settings[ph].odim);
      if (ph == 3) begin
        // indexes past the register list must be ignored
        cfg_write(3'd5, 16'hffff);
        cfg_write(3'd7, 16'h0000);
      end
      @(posedge clk);
      cfg_we <= 1'b0;
      @(posedge clk);

      case (ph % 3)
        0: begin send_idle = 35; recv_idle = 57; end
        1: begin send_idle = 57; recv_idle = 35; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase

      for (int n = 0; n < RAND_PER_PH; n++) begin
        q = noise_req();
        pick = $urandom_range(99);
        if (pick < 45) begin
          // class mostly within range, now and then past it
          if ($urandom_range(4) != 0 && cur_odim > 0)
            q.class_index = $urandom_range(cur_odim - 1);
          roi_axis((cur_fw > FEAT_DIM) ? FEAT_DIM : cur_fw, q.roi_x1, q.roi_x2);
          roi_axis((cur_fh > FEAT_DIM) ? FEAT_DIM : cur_fh, q.roi_y1, q.roi_y2);
          push_pool(q);
        end else begin
          push_write(q);
        end
      end
      if (ph == 1) hold_go = 1'b1;
      wait_drained();
    end

    while (bin_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && bin_q.size() == 0) begin
      $display("** psroi_pool_forward_unit: PASSED **");
    end else begin
      $display("** psroi_pool_forward_unit: FAILED **");
    end
    $finish;
  end

endmodule
